FILE: rtl/psm_pkg.sv
// Package for the page slot manager: payload structs, RAM request struct,
// command/status/register codes and table geometry. No dependencies.
package psm_pkg;

  localparam int unsigned SLOT_COUNT = 1024;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned FRAME_W    = 20;
  localparam int unsigned ENTRY_W    = FRAME_W + 1;
  localparam int unsigned IDX_W      = SLOT_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;
  localparam logic [1:0] CMD_XLATE = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_TABLE = 2'd1;
  localparam logic [1:0] ST_NO_ENTRY = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_END = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_DIR = 2'd1;

  localparam logic [9:0] WINDOW_DIR_RESET = 10'd768;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] virt_address;
    logic [19:0] frame_number;
  } psm_in_t;

  typedef struct packed {
    logic [31:0] address_out;
    logic [19:0] freed_frame;
    logic [1:0]  status;
  } psm_out_t;

  typedef struct packed {
    logic [31:0] kernel_end;
    logic [9:0]  window_dir_index;
  } psm_cfg_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [SLOT_W-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
  } psm_ram_req_t;

endpackage

FILE: rtl/psm_ram.sv
// Generic single-port RAM with registered read data.
// Standalone; no package dependency.
module psm_ram #(
  parameter int unsigned Width = 21,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/psm_ctrl.sv
// Sequencer for the page slot manager: command decode, shared slot index
// counter and compare for init sweep and free-slot scan, result register.
// Depends on psm_pkg.
module psm_ctrl import psm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  psm_in_t            in_data_i,
  input  psm_cfg_t           cfg_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output psm_out_t           out_data_o,
  output psm_ram_req_t       ram_req_o,
  input  logic [ENTRY_W-1:0] ram_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_AWR, S_SCAN, S_LOOK, S_CHECK, S_DONE
  } state_e;

  state_e            state_q;
  psm_in_t           item_q;
  psm_out_t          res_q;
  psm_out_t          out_q;
  logic              out_valid_q;
  logic              table_ready_q;
  logic              hint_valid_q;
  logic [SLOT_W-1:0] hint_q;
  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  count_q;
  logic [SLOT_W-1:0] last_q;
  logic              pend_q;

  logic [12:0]       raw_count;
  logic [IDX_W-1:0]  init_count;
  logic              in_acc;
  logic              present;
  logic              found;
  logic [SLOT_W-1:0] look_slot;
  logic              out_load;

  assign raw_count  = {1'b0, cfg_i.kernel_end[23:12]} + 13'd1;
  assign init_count = (raw_count > 13'(SLOT_COUNT)) ? IDX_W'(SLOT_COUNT)
                                                    : raw_count[IDX_W-1:0];
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign present    = ram_rdata_i[ENTRY_W-1];
  assign found      = pend_q && !present;
  assign look_slot  = item_q.virt_address[21:12];
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    ram_req_o = '0;
    unique case (state_q)
      S_INIT: begin
        ram_req_o.we   = 1'b1;
        ram_req_o.addr = idx_q[SLOT_W-1:0];
        if (idx_q < count_q) begin
          ram_req_o.wdata = {1'b1, (FRAME_W - SLOT_W)'(0), idx_q[SLOT_W-1:0]};
        end
      end
      S_AWR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = hint_q;
        ram_req_o.wdata = {1'b1, item_q.frame_number};
      end
      S_SCAN: begin
        ram_req_o.re   = !found && !idx_q[IDX_W-1];
        ram_req_o.addr = idx_q[SLOT_W-1:0];
      end
      S_LOOK: begin
        ram_req_o.re   = 1'b1;
        ram_req_o.addr = look_slot;
      end
      S_CHECK: begin
        ram_req_o.we   = (item_q.cmd == CMD_FREE) && present;
        ram_req_o.addr = look_slot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      item_q        <= '0;
      res_q         <= '0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
      table_ready_q <= 1'b0;
      hint_valid_q  <= 1'b0;
      hint_q        <= '0;
      idx_q         <= '0;
      count_q       <= '0;
      last_q        <= '0;
      pend_q        <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            item_q <= in_data_i;
            unique case (in_data_i.cmd)
              CMD_INIT: begin
                res_q   <= '0;
                count_q <= init_count;
                idx_q   <= '0;
                state_q <= S_INIT;
              end
              CMD_ALLOC: begin
                if (!table_ready_q) begin
                  res_q   <= '{address_out: '0, freed_frame: '0, status: ST_NO_TABLE};
                  state_q <= S_DONE;
                end else if (!hint_valid_q) begin
                  res_q   <= '{address_out: '0, freed_frame: '0, status: ST_FULL};
                  state_q <= S_DONE;
                end else begin
                  res_q   <= '{address_out: {cfg_i.window_dir_index, hint_q, 12'h000},
                               freed_frame: '0, status: ST_OK};
                  state_q <= S_AWR;
                end
              end
              default: begin
                if (!table_ready_q ||
                    in_data_i.virt_address[31:22] != cfg_i.window_dir_index) begin
                  res_q   <= '{address_out: '0, freed_frame: '0, status: ST_NO_TABLE};
                  state_q <= S_DONE;
                end else begin
                  res_q   <= '0;
                  state_q <= S_LOOK;
                end
              end
            endcase
          end
        end
        S_INIT: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q[SLOT_W-1:0] == SLOT_W'(SLOT_COUNT - 1)) begin
            table_ready_q <= 1'b1;
            hint_valid_q  <= !count_q[IDX_W-1];
            hint_q        <= count_q[SLOT_W-1:0];
            state_q       <= S_DONE;
          end
        end
        S_AWR: begin
          idx_q   <= '0;
          pend_q  <= 1'b0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (found) begin
            hint_q       <= last_q;
            hint_valid_q <= 1'b1;
            state_q      <= S_DONE;
          end else if (idx_q[IDX_W-1]) begin
            hint_valid_q <= 1'b0;
            state_q      <= S_DONE;
          end else begin
            last_q <= idx_q[SLOT_W-1:0];
            idx_q  <= idx_q + 1'b1;
            pend_q <= 1'b1;
          end
        end
        S_LOOK: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (!present) begin
            res_q.status <= ST_NO_ENTRY;
          end else if (item_q.cmd == CMD_FREE) begin
            res_q.freed_frame <= ram_rdata_i[FRAME_W-1:0];
            hint_q            <= look_slot;
            hint_valid_q      <= 1'b1;
          end else begin
            res_q.address_out <= {ram_rdata_i[FRAME_W-1:0],
                                  item_q.virt_address[11:0]};
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req_o.we && ram_req_o.re))
    else $error("RAM read and write in the same cycle");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("ready held after accepting a beat");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside done state");

  a_write_needs_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req_o.we && !table_ready_q) |-> (state_q == S_INIT))
    else $error("table written before init");

endmodule

FILE: rtl/page_slot_manager_top.sv
// Page slot manager: init makes one RAM write per slot, alloc a write plus a
// pipelined first-free scan.
// One command in flight; next beat accepted once the result sits in the output
// register. Reset clears control state only: slot RAM is never read before the
// first init, which rewrites every slot, so no clearing pass runs.
// Depends on psm_pkg, psm_ram and psm_ctrl.
module page_slot_manager_top import psm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  psm_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output psm_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  psm_cfg_t           cfg_q;
  psm_ram_req_t       ram_req;
  logic [ENTRY_W-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kernel_end       <= '0;
      cfg_q.window_dir_index <= WINDOW_DIR_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_KERNEL_END) begin
        cfg_q.kernel_end <= cfg_data_i;
      end else if (cfg_index_i == REG_WINDOW_DIR) begin
        cfg_q.window_dir_index <= cfg_data_i[9:0];
      end
    end
  end

  psm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  psm_ram #(
    .Width (ENTRY_W),
    .Depth (SLOT_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .re_i    (ram_req.re),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: verif/page_slot_manager_top_tb.sv
// Testbench for page_slot_manager_top: directed and random page-table commands
// checked beat by beat against an in-bench model of the slot table.
// Depends on psm_pkg and the page_slot_manager_top RTL.
module page_slot_manager_top_tb;
  import psm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned END_WAIT    = 1100;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  psm_in_t              in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  psm_out_t             out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i = '0;

  // table model
  logic [FRAME_W-1:0] tbl_frame [SLOT_COUNT];
  logic               tbl_present [SLOT_COUNT];
  logic [SLOT_W-1:0]  hint_slot = '0;
  logic               hint_valid = 1'b0;
  logic               table_live = 1'b0;
  logic [31:0]        kernel_end_reg = '0;
  logic [9:0]         window_dir_reg = WINDOW_DIR_RESET;

  psm_out_t    pending_page_results [$];
  psm_out_t    got_result;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  page_slot_manager_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_page_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        fail_count++;
      end else begin
        got_result = pending_page_results.pop_front();
        if (out_data_o.address_out !== got_result.address_out) begin
          $error("address_out: expected %h, got %h",
                 got_result.address_out, out_data_o.address_out);
          fail_count++;
        end
        if (out_data_o.freed_frame !== got_result.freed_frame) begin
          $error("freed_frame: expected %h, got %h",
                 got_result.freed_frame, out_data_o.freed_frame);
          fail_count++;
        end
        if (out_data_o.status !== got_result.status) begin
          $error("status: expected %0d, got %0d", got_result.status, out_data_o.status);
          fail_count++;
        end
      end
    end
  end

  function automatic psm_out_t predict_page_op(input psm_in_t beat);
    psm_out_t    res;
    int unsigned cnt;
    int          i;
    logic [SLOT_W-1:0] slot;
    res = '0;
    case (beat.cmd)
      CMD_INIT: begin
        cnt = ((kernel_end_reg & 32'h00FF_F000) + 32'h1000) >> 12;
        if (cnt > SLOT_COUNT) cnt = SLOT_COUNT;
        for (i = 0; i < SLOT_COUNT; i++) begin
          tbl_present[i] = (i < cnt);
          tbl_frame[i]   = (i < cnt) ? FRAME_W'(i) : '0;
        end
        hint_valid = (cnt < SLOT_COUNT);
        hint_slot  = hint_valid ? SLOT_W'(cnt) : '0;
        table_live = 1'b1;
      end
      CMD_ALLOC: begin
        if (!table_live) begin
          res.status = ST_NO_TABLE;
        end else if (!hint_valid) begin
          res.status = ST_FULL;
        end else begin
          tbl_frame[hint_slot]   = beat.frame_number;
          tbl_present[hint_slot] = 1'b1;
          res.address_out = {window_dir_reg, hint_slot, 12'h000};
          // lowest free slot becomes the new hint
          hint_valid = 1'b0;
          for (i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!tbl_present[i]) begin
              hint_slot  = SLOT_W'(i);
              hint_valid = 1'b1;
            end
          end
        end
      end
      default: begin
        slot = beat.virt_address[21:12];
        if (!table_live || beat.virt_address[31:22] != window_dir_reg) begin
          res.status = ST_NO_TABLE;
        end else if (!tbl_present[slot]) begin
          res.status = ST_NO_ENTRY;
        end else if (beat.cmd == CMD_FREE) begin
          res.freed_frame   = tbl_frame[slot];
          tbl_frame[slot]   = '0;
          tbl_present[slot] = 1'b0;
          hint_slot         = slot;
          hint_valid        = 1'b1;
        end else begin
          res.address_out = {tbl_frame[slot], beat.virt_address[11:0]};
        end
      end
    endcase
    return res;
  endfunction

  function automatic logic [31:0] slot_va(input logic [SLOT_W-1:0] slot);
    return {window_dir_reg, slot, 12'($urandom())};
  endfunction

  function automatic int pick_present_slot();
    int start;
    int i;
    start = $urandom_range(SLOT_COUNT - 1);
    for (i = 0; i < SLOT_COUNT; i++) begin
      if (tbl_present[(start + i) % SLOT_COUNT]) return (start + i) % SLOT_COUNT;
    end
    return -1;
  endfunction

  // valid is left high after the beat; the drain lowers it, the next call only before an idle gap
  task automatic send_beat(input logic [1:0] cmd, input logic [31:0] va,
                           input logic [FRAME_W-1:0] frame);
    psm_in_t     beat;
    int unsigned gap;
    beat.cmd          = cmd;
    beat.virt_address = va;
    beat.frame_number = frame;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    pending_page_results.push_back(predict_page_op(beat));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_page_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_KERNEL_END: kernel_end_reg = data;
      REG_WINDOW_DIR: window_dir_reg = data[9:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic test_before_init();
    write_reg(REG_SPARE_2, $urandom());
    write_reg(REG_SPARE_3, $urandom());
    send_beat(CMD_ALLOC, $urandom(), 20'($urandom()));
    send_beat(CMD_FREE, {WINDOW_DIR_RESET, 22'h0}, '0);
    send_beat(CMD_XLATE, {WINDOW_DIR_RESET, 22'h0_0123}, '0);
    wait_for_results();
  endtask

  task automatic test_full_table();
    write_reg(REG_KERNEL_END, 32'hFFFF_FFFF);
    write_reg(REG_WINDOW_DIR, 32'hFFFF_FFFF);
    send_beat(CMD_INIT, $urandom(), 20'($urandom()));
    send_beat(CMD_ALLOC, '0, 20'h1_2345);
    send_beat(CMD_XLATE, 32'hFFFF_FFFF, '0);
    send_beat(CMD_FREE, {10'h3FF, 10'd5, 12'h000}, '0);
    send_beat(CMD_ALLOC, 32'hFFFF_FFFF, 20'hF_FFFF);
    send_beat(CMD_XLATE, {10'h3FF, 10'd5, 12'hABC}, '0);
    send_beat(CMD_ALLOC, '0, 20'h0_0001);
    wait_for_results();
  endtask

  task automatic test_single_free_slot();
    write_reg(REG_KERNEL_END, 32'h003F_E000);
    write_reg(REG_WINDOW_DIR, 32'h0000_0000);
    send_beat(CMD_INIT, '0, '0);
    send_beat(CMD_ALLOC, '0, 20'h0_0000);
    send_beat(CMD_ALLOC, '0, 20'h5_5555);
    send_beat(CMD_XLATE, 32'h0040_0000, '0);
    send_beat(CMD_FREE, 32'h0000_0000, '0);
    send_beat(CMD_XLATE, 32'h0000_0FFF, '0);
    send_beat(CMD_FREE, 32'h0000_0800, '0);
    send_beat(CMD_ALLOC, '0, 20'hA_5A5A);
    wait_for_results();
  endtask

  task automatic test_init_count_limits();
    write_reg(REG_KERNEL_END, 32'h0000_0000);
    write_reg(REG_WINDOW_DIR, {22'h0, WINDOW_DIR_RESET});
    send_beat(CMD_INIT, '0, '0);
    send_beat(CMD_XLATE, {WINDOW_DIR_RESET, 10'd0, 12'h800}, '0);
    send_beat(CMD_ALLOC, '0, 20'h8_0000);
    send_beat(CMD_XLATE, {WINDOW_DIR_RESET, 10'd2, 12'h000}, '0);
    wait_for_results();
    // count one past the table size clamps to a full table
    write_reg(REG_KERNEL_END, 32'h0040_0000);
    send_beat(CMD_INIT, '0, '0);
    send_beat(CMD_ALLOC, '0, 20'h0_00FF);
    wait_for_results();
  endtask

  task automatic run_random_segment(input int unsigned n_items);
    int unsigned cnt;
    int unsigned pick;
    int          slot;
    logic [1:0]  cmd;
    logic [31:0] va;
    wait_for_results();
    if ($urandom_range(8) == 0) cnt = $urandom_range(SLOT_COUNT, 990);
    else cnt = $urandom_range(64, 1);
    write_reg(REG_KERNEL_END, {8'($urandom()), 12'(cnt - 1), 12'($urandom())});
    write_reg(REG_WINDOW_DIR, $urandom());
    if ($urandom_range(2) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, $urandom());
    send_beat(CMD_INIT, $urandom(), 20'($urandom()));
    repeat (n_items) begin
      pick = $urandom_range(99);
      cmd  = $urandom_range(1) ? CMD_FREE : CMD_XLATE;
      va   = $urandom();
      if (pick < 2) begin
        cmd = CMD_INIT;
      end else if (pick < 32) begin
        cmd = CMD_ALLOC;
      end else if (pick < 92) begin
        cmd  = (pick < 57) ? CMD_FREE : CMD_XLATE;
        slot = pick_present_slot();
        if (slot >= 0) va = slot_va(SLOT_W'(slot));
      end else if (pick < 97) begin
        va = slot_va(SLOT_W'($urandom()));
      end
      send_beat(cmd, va, 20'($urandom()));
    end
  endtask

  task automatic test_random_traffic();
    int m;
    for (m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 27 : (m == 1) ? 77 : 0;
      recv_idle_pct = (m == 0) ? 77 : (m == 1) ? 27 : 0;
      repeat (3) run_random_segment(62);
    end
    wait_for_results();
  endtask

  initial begin
    send_idle_pct = 27;
    recv_idle_pct = 77;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_before_init();
    test_full_table();
    test_single_free_slot();
    test_init_count_limits();
    test_random_traffic();
    repeat (END_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
